// ===== sv/lfp_pkg.sv =====
package lfp_pkg;

	localparam logic [7:0]  HDR_BYTE          = 8'h59;
	localparam logic [15:0] NO_FRAME_STRENGTH = 16'd65534;
	localparam logic [13:0] TEMP_OFFSET       = 14'd256;
	localparam logic [2:0]  PAYLOAD_LEN       = 3'd6;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_ONE     = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	typedef enum logic [0:0] {
		OP_DATA       = 1'b0,
		OP_WINDOW_END = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_GOOD      = 2'd0,
		ST_BAD_SUM   = 2'd1,
		ST_ZERO_DIST = 2'd2,
		ST_NO_FRAME  = 2'd3
	} status_t;

	typedef struct packed {
		logic [19:0]        distance_mm;
		logic [15:0]        strength;
		logic signed [13:0] temperature;
		status_t            status;
	} result_t;

endpackage

// ===== sv/lfp_parser.sv =====
module lfp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [0:0]         opcode,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	output lfp_pkg::result_t   res
);
	import lfp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] count_q, count_d;
	logic [7:0] sum_q, sum_d;
	logic       taken_q, taken_d;
	logic [7:0] payload_q [PAYLOAD_LEN];

	logic [15:0] dist_raw, str_raw, temp_raw;

	assign dist_raw = {payload_q[1], payload_q[0]};
	assign str_raw  = {payload_q[3], payload_q[2]};
	assign temp_raw = {payload_q[5], payload_q[4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 3'd0;
			sum_q   <= 8'd0;
			taken_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			taken_q <= taken_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && opcode == OP_DATA && !taken_q && phase_q == PH_COLLECT
				&& count_q < PAYLOAD_LEN) begin
			payload_q[count_q] <= rx_byte;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		sum_d     = sum_q;
		taken_d   = taken_q;
		res_valid = 1'b0;
		res       = '0;
		if (opcode == OP_WINDOW_END) begin
			if (!taken_q) begin
				res_valid       = 1'b1;
				res.distance_mm = 20'd0;
				res.strength    = NO_FRAME_STRENGTH;
				res.temperature = 14'sd0;
				res.status      = ST_NO_FRAME;
			end
			phase_d = PH_HUNT;
			count_d = 3'd0;
			sum_d   = 8'd0;
			taken_d = 1'b0;
		end else if (!taken_q) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == HDR_BYTE) begin
						phase_d = PH_ONE;
						sum_d   = HDR_BYTE;
					end
				end
				PH_ONE: begin
					if (rx_byte == HDR_BYTE) begin
						phase_d = PH_COLLECT;
						count_d = 3'd0;
						sum_d   = sum_q + HDR_BYTE;
					end else begin
						phase_d = PH_HUNT;
						count_d = 3'd0;
						sum_d   = 8'd0;
					end
				end
				PH_COLLECT: begin
					if (count_q < PAYLOAD_LEN) begin
						sum_d   = sum_q + rx_byte;
						count_d = count_q + 3'd1;
					end else begin
						// checksum byte closes the frame
						res_valid       = 1'b1;
						res.distance_mm = ({4'd0, dist_raw} << 3) + ({4'd0, dist_raw} << 1);
						res.strength    = str_raw;
						res.temperature = $signed({1'b0, temp_raw[15:3]} - TEMP_OFFSET);
						if (sum_q != rx_byte)
							res.status = ST_BAD_SUM;
						else if (dist_raw == 16'd0)
							res.status = ST_ZERO_DIST;
						else
							res.status = ST_GOOD;
						phase_d = PH_HUNT;
						count_d = 3'd0;
						sum_d   = 8'd0;
						taken_d = 1'b1;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					count_d = 3'd0;
					sum_d   = 8'd0;
				end
			endcase
		end
	end

endmodule

// ===== sv/lfp_out_fifo.sv =====
module lfp_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lfp_pkg::result_t push_data,
	input  logic             pop,
	output logic             empty,
	output logic             full,
	output logic [1:0]       fill,
	output lfp_pkg::result_t head
);
	import lfp_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign empty = (fill_q == 2'd0);
	assign full  = (fill_q == 2'd2);
	assign fill  = fill_q;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/lidar_frame_parser.sv =====
// rangefinder frame parser
// input channel: item_valid / item_stall with opcode and rx_byte. opcode 0 carries one
// received serial byte, opcode 1 marks the end of a capture window.
// result channel: result_valid / result_stall with distance_mm, strength, temperature
// and status. the first frame (header 59 59, six payload bytes, checksum) in a window
// gives one result on its checksum byte; a window end with no frame gives a no-frame
// result; all other items give none.
// an item is accepted into an input register, parsed by the sync state machine once the
// output queue is not full, and its result written to that two-entry queue, from which
// it shows on the result port. throughput is one item per cycle while item_stall is low.
// when the receiver stalls, the queue absorbs up to two results; once it is full and the
// input register holds an item, item_stall rises until a result is taken.
// reset (arst_n low) empties the queue and input register and sets the parser to hunt
// for a header with no frame taken in the current window.
module lidar_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [0:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [19:0]        distance_mm,
	output logic [15:0]        strength,
	output logic signed [13:0] temperature,
	output logic [1:0]         status
);
	import lfp_pkg::*;

	logic       valid_s1;
	logic [0:0] opcode_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;
	logic       accept;
	logic       res_valid;
	result_t    res;
	logic       q_empty, q_full, q_pop;
	logic [1:0] q_fill;
	result_t    q_head;

	assign advance    = valid_s1 && !q_full;
	assign item_stall = valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1  <= opcode;
			rx_byte_s1 <= rx_byte;
		end
	end

	lfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.opcode    (opcode_s1),
		.rx_byte   (rx_byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	assign q_pop = result_valid && !result_stall;

	lfp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.push_data (res),
		.pop       (q_pop),
		.empty     (q_empty),
		.full      (q_full),
		.fill      (q_fill),
		.head      (q_head)
	);

	assign result_valid = !q_empty;
	assign distance_mm  = q_head.distance_mm;
	assign strength     = q_head.strength;
	assign temperature  = q_head.temperature;
	assign status       = q_head.status;

	// queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill != 2'd3)
		else $error("output queue fill out of range");

	// stall only while an item sits in the input register
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("stall without a held item");

	// a result pushed into an empty queue with no pop appears next cycle
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && q_empty) |=> result_valid)
		else $error("result missing one cycle after parse");

	// a stalled result stays put
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(q_head)))
		else $error("stalled result changed");

endmodule
